@@ design/chacha_pkg.sv @@
`default_nettype none

package chacha_pkg;

   localparam int DOUBLE_ROUNDS = 10;
   localparam int DBL_W = $clog2(DOUBLE_ROUNDS);

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_0         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_1         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_2         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_3         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_LOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NONCE_HIGH    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_COUNTER = 3'd6;

   typedef logic [31:0] word_type;
   typedef word_type [3:0] row_type;

   typedef struct packed {
      logic [63:0] key_0;
      logic [63:0] key_1;
      logic [63:0] key_2;
      logic [63:0] key_3;
      logic [63:0] nonce_low;
      logic [31:0] nonce_high;
      logic [31:0] first_counter;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] counter;
   } core_cmd_type;

   function automatic row_type rotl_row(row_type r, logic [1:0] k);
      row_type res;
      logic [1:0] idx;
      for (int j = 0; j < 4; j++) begin
         idx = 2'(j) + k;
         res[j] = r[idx];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/chacha_csr.sv @@
`default_nettype none

module chacha_csr
   import chacha_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KEY_0:         cfg_in.key_0 = csr_data;
            REG_KEY_1:         cfg_in.key_1 = csr_data;
            REG_KEY_2:         cfg_in.key_2 = csr_data;
            REG_KEY_3:         cfg_in.key_3 = csr_data;
            REG_NONCE_LOW:     cfg_in.nonce_low = csr_data;
            REG_NONCE_HIGH:    cfg_in.nonce_high = csr_data[31:0];
            REG_FIRST_COUNTER: cfg_in.first_counter = csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key_0: 64'd0, key_1: 64'd0, key_2: 64'd0, key_3: 64'd0,
                     nonce_low: 64'd0, nonce_high: 32'd0, first_counter: 32'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ design/chacha_qr.sv @@
`default_nettype none

module chacha_qr
   import chacha_pkg::*;
(
   input  wire word_type a_i,
   input  wire word_type b_i,
   input  wire word_type c_i,
   input  wire word_type d_i,
   input  wire logic     phase,
   output word_type      a_o,
   output word_type      b_o,
   output word_type      c_o,
   output word_type      d_o
);

   word_type dx;
   word_type bx;

   // The first half rotates by 16 and 12, the second half by 8 and 7.
   always_comb begin
      a_o = a_i + b_i;
      dx  = d_i ^ a_o;
      d_o = phase ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
      c_o = c_i + d_o;
      bx  = b_i ^ c_o;
      b_o = phase ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
   end

endmodule

`default_nettype wire

@@ design/chacha_core.sv @@
`default_nettype none

module chacha_core
   import chacha_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire core_cmd_type cmd,
   input  wire logic [2:0]   pos,
   output logic              done,
   output logic [63:0]       ks_word
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROUND = 3'b010,
      C_FINAL = 3'b100
   } core_state_type;

   core_state_type state_ff, state_in;
   row_type [3:0]  st_ff, st_in;
   row_type [3:0]  upd;
   row_type [3:0]  init_st;
   logic [31:0]    ctr_ff, ctr_in;
   logic [31:0]    init_ctr;
   logic           phase_ff, phase_in;
   logic [1:0]     col_ff, col_in;
   logic           diag_ff, diag_in;
   logic [DBL_W-1:0] dbl_ff, dbl_in;
   logic           done_ff, done_in;
   word_type       qa, qb, qc, qd;
   logic [1:0]     rr;
   logic [1:0]     rot;

   chacha_qr u_qr (
      .a_i   (st_ff[0][0]),
      .b_i   (st_ff[1][0]),
      .c_i   (st_ff[2][0]),
      .d_i   (st_ff[3][0]),
      .phase (phase_ff),
      .a_o   (qa),
      .b_o   (qb),
      .c_o   (qc),
      .d_o   (qd)
   );

   assign init_ctr = (state_ff == C_IDLE) ? cmd.counter : ctr_ff;
   assign init_st[0] = {SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};
   assign init_st[1] = {cfg.key_1, cfg.key_0};
   assign init_st[2] = {cfg.key_3, cfg.key_2};
   assign init_st[3] = {cfg.nonce_high, cfg.nonce_low, init_ctr};

   assign done = done_ff;
   assign ks_word = {st_ff[pos[2:1]][{pos[0], 1'b1}], st_ff[pos[2:1]][{pos[0], 1'b0}]};

   // The quarter round always works on column 0. After each one the rows shift
   // left so the next column moves in; at the end of a column round the rows are
   // skewed so the diagonals line up, and at the end of a diagonal round unskewed.
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      ctr_in   = ctr_ff;
      phase_in = phase_ff;
      col_in   = col_ff;
      diag_in  = diag_ff;
      dbl_in   = dbl_ff;
      done_in  = 1'b0;
      upd      = st_ff;
      rr       = 2'd0;
      rot      = 2'd0;
      upd[0][0] = qa;
      upd[1][0] = qb;
      upd[2][0] = qc;
      upd[3][0] = qd;
      unique case (state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               st_in    = init_st;
               ctr_in   = cmd.counter;
               phase_in = 1'b0;
               col_in   = 2'd0;
               diag_in  = 1'b0;
               dbl_in   = '0;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            phase_in = ~phase_ff;
            if (!phase_ff) begin
               st_in = upd;
            end else begin
               for (int r = 0; r < 4; r++) begin
                  rr = 2'(r);
                  if (col_ff != 2'd3) begin
                     rot = 2'd1;
                  end else if (diag_ff) begin
                     rot = 2'd1 - rr;
                  end else begin
                     rot = 2'd1 + rr;
                  end
                  st_in[r] = rotl_row(upd[r], rot);
               end
               col_in = col_ff + 2'd1;
               if (col_ff == 2'd3) begin
                  diag_in = ~diag_ff;
                  if (diag_ff) begin
                     dbl_in = dbl_ff + DBL_W'(1);
                     if (dbl_ff == DBL_W'(DOUBLE_ROUNDS - 1)) begin
                        state_in = C_FINAL;
                     end
                  end
               end
            end
         end
         C_FINAL: begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  st_in[r][c] = st_ff[r][c] + init_st[r][c];
               end
            end
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         col_ff   <= 2'd0;
         diag_ff  <= 1'b0;
         dbl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         col_ff   <= col_in;
         diag_ff  <= diag_in;
         dbl_ff   <= dbl_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff  <= st_in;
      ctr_ff <= ctr_in;
   end

endmodule

`default_nettype wire

@@ design/chacha20_stream_cipher.sv @@
// ChaCha20 stream cipher, keystream per RFC 8439 (20 rounds, 96-bit nonce,
// 32-bit block counter), applied to message words of up to eight bytes.
// Input channel req_*: a beat carries req_data_in (byte 0 in bits 7:0),
// req_byte_count and req_last. Result channel rsp_*: one beat per input beat,
// with data XOR keystream, bytes beyond the count forced to zero.
// Configuration channel csr_*: key, nonce, start counter; csr_ready is tied high.
// The user writes them by index only while no message word is in flight (unenforced).
// The first word of a message and every eighth word after it start a new
// keystream block. Their result is computed by one shared half quarter-round
// unit, which runs the ten double rounds; then the input block is added and
// the output register is loaded. Every other word's result is registered in
// the cycle after its beat.
// The input stalls while a block is computed and while the output register
// is full and its receiver stalls; a stalled result holds its value.
// Reset clears the configuration (start counter to 1), the output register
// and the message position, so the next word starts a new message.
`default_nettype none

module chacha20_stream_cipher
   import chacha_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [63:0]          req_data_in,
   input  wire logic [3:0]           req_byte_count,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [63:0]               rsp_data_out,
   output logic [3:0]                rsp_byte_count_out,
   output logic                      rsp_last_out,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_data
);

   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_WAIT = 2'b10
   } top_state_type;

   top_state_type state_ff, state_in;
   cfg_type       cfg;
   core_cmd_type  cmd;
   logic          core_done;
   logic [63:0]   ks_word;
   logic [2:0]    ks_pos;

   logic          in_message_ff, in_message_in;
   logic [2:0]    pos_ff, pos_in;
   logic [31:0]   counter_ff, counter_in;
   logic [63:0]   data_ff, data_in;
   logic [3:0]    count_ff, count_in;
   logic          last_ff, last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic [3:0]    rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          load;
   logic [2:0]    pos_eff;
   logic [31:0]   ctr_eff;
   logic [63:0]   src_data;
   logic [3:0]    src_count;
   logic          src_last;
   logic [63:0]   mask;

   chacha_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   chacha_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .pos     (ks_pos),
      .done    (core_done),
      .ks_word (ks_word)
   );

   assign req_stall = !((state_ff == T_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign pos_eff = in_message_ff ? pos_ff : 3'd0;
   assign ctr_eff = in_message_ff ? counter_ff : cfg.first_counter;
   assign ks_pos  = (state_ff == T_WAIT) ? 3'd0 : pos_eff;

   assign cmd = '{start: accept && (pos_eff == 3'd0), counter: ctr_eff};

   assign src_data  = (state_ff == T_WAIT) ? data_ff : req_data_in;
   assign src_count = (state_ff == T_WAIT) ? count_ff : req_byte_count;
   assign src_last  = (state_ff == T_WAIT) ? last_ff : req_last;

   assign load = (accept && (pos_eff != 3'd0)) || ((state_ff == T_WAIT) && core_done);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask[8*i +: 8] = (4'(i) < src_count) ? 8'hff : 8'h00;
      end
   end

   always_comb begin
      state_in      = state_ff;
      in_message_in = in_message_ff;
      pos_in        = pos_ff;
      counter_in    = counter_ff;
      data_in       = data_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (accept) begin
         data_in       = req_data_in;
         count_in      = req_byte_count;
         last_in       = req_last;
         in_message_in = !req_last;
         pos_in        = pos_eff + 3'd1;
         if (pos_eff == 3'd0) begin
            counter_in = ctr_eff + 32'd1;
            state_in   = T_WAIT;
         end
      end
      if ((state_ff == T_WAIT) && core_done) begin
         state_in = T_IDLE;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (src_data ^ ks_word) & mask;
         rsp_count_in = src_count;
         rsp_last_in  = src_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         in_message_ff <= 1'b0;
         pos_ff        <= 3'd0;
         counter_ff    <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_message_ff <= in_message_in;
         pos_ff        <= pos_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff      <= data_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_byte_count_out = rsp_count_ff;
   assign rsp_last_out       = rsp_last_ff;

endmodule

`default_nettype wire
